@@ design/fsneh_pkg.sv @@
// Shared types and constants of the flow-shop NEH scheduler.
`default_nettype none

package fsneh_pkg;

    localparam int DEF_MAX_JOBS     = 32;
    localparam int DEF_MAX_MACHINES = 16;
    localparam int DEF_TIME_BITS    = 16;

    localparam int JOB_COUNT_W  = 6;
    localparam int MACH_COUNT_W = 5;
    localparam int CFG_DATA_W   = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int JOB_INDEX_W  = 5;
    localparam int SPAN_OUT_W   = 22;

    localparam logic [SPAN_OUT_W-1:0] SPAN_MAX = 22'h3F_FFFF;

    localparam logic [CFG_IDX_W-1:0] REG_JOB_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MACHINE_COUNT = 2'd1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_WSUM,
        OP_SPAN
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WSUM,
        S_WDRAIN,
        S_SORT,
        S_TRY,
        S_IDRAIN,
        S_INSERT,
        S_FINAL,
        S_FDRAIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_op  op;
        logic load;
        logic init;
        logic first_m;
        logic last_m;
        logic first_n;
        logic eval_end;
        logic plain;
        logic insert;
        logic sort_en;
        logic emit;
        logic emit_last;
    } t_dp_cmd;

endpackage

`default_nettype wire

@@ design/fsneh_ctrl.sv @@
// Sequencer of the NEH scheduler: configuration, loop counters and phase control.
`default_nettype none

module fsneh_ctrl #(
    parameter int MAX_JOBS     = fsneh_pkg::DEF_MAX_JOBS,
    parameter int MAX_MACHINES = fsneh_pkg::DEF_MAX_MACHINES,
    localparam int JW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1,
    localparam int MW  = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1,
    localparam int NCW = $clog2(MAX_JOBS + 1),
    localparam int MCW = $clog2(MAX_MACHINES + 1)
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic                             i_last_time,
    input  wire logic                             i_cfg_we,
    input  wire logic [fsneh_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fsneh_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                  o_busy,
    output fsneh_pkg::t_dp_cmd                    o_cmd,
    output logic [JW-1:0]                         o_n,
    output logic [MW-1:0]                         o_m,
    output logic [JW-1:0]                         o_s,
    output logic [JW-1:0]                         o_k,
    output logic [NCW-1:0]                        o_nj,
    output logic [MCW-1:0]                        o_nm
);
    import fsneh_pkg::*;

    t_state                   r_state, n_state;
    logic [JW-1:0]            r_n, n_n, r_s, n_s, r_k, n_k;
    logic [MW-1:0]            r_m, n_m;
    logic [JOB_COUNT_W-1:0]   r_job_count;
    logic [MACH_COUNT_W-1:0]  r_mach_count;
    logic [JW-1:0]            nj_last;
    logic [MW-1:0]            nm_last;
    logic                     m_last;
    t_dp_cmd                  cmd;

    // clamp the counts into the supported range
    always_comb begin
        if (r_job_count == '0) begin
            o_nj = NCW'(1);
        end else if ({1'b0, r_job_count} > (JOB_COUNT_W + 1)'(MAX_JOBS)) begin
            o_nj = NCW'(MAX_JOBS);
        end else begin
            o_nj = NCW'(r_job_count);
        end
        if (r_mach_count == '0) begin
            o_nm = MCW'(1);
        end else if ({1'b0, r_mach_count} > (MACH_COUNT_W + 1)'(MAX_MACHINES)) begin
            o_nm = MCW'(MAX_MACHINES);
        end else begin
            o_nm = MCW'(r_mach_count);
        end
    end

    assign nj_last = JW'(o_nj - NCW'(1));
    assign nm_last = MW'(o_nm - MCW'(1));
    assign m_last  = (r_m == nm_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_n          <= '0;
            r_m          <= '0;
            r_s          <= '0;
            r_k          <= '0;
            r_job_count  <= JOB_COUNT_W'(1);
            r_mach_count <= MACH_COUNT_W'(1);
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_m     <= n_m;
            r_s     <= n_s;
            r_k     <= n_k;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_JOB_COUNT:     r_job_count  <= JOB_COUNT_W'(i_cfg_data);
                    REG_MACHINE_COUNT: r_mach_count <= MACH_COUNT_W'(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_m     = r_m;
        n_s     = r_s;
        n_k     = r_k;
        cmd     = '0;
        cmd.op  = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    if (i_last_time) begin
                        cmd.init = 1'b1;
                        n_state  = S_WSUM;
                        n_n      = '0;
                        n_m      = '0;
                    end
                end
            end
            S_WSUM: begin
                cmd.op      = OP_WSUM;
                cmd.first_m = (r_m == '0);
                cmd.last_m  = m_last;
                if (m_last) begin
                    n_m = '0;
                    if (r_n == nj_last) begin
                        n_state = S_WDRAIN;
                    end else begin
                        n_n = r_n + JW'(1);
                    end
                end else begin
                    n_m = r_m + MW'(1);
                end
            end
            S_WDRAIN: begin
                n_n     = '0;
                n_state = S_SORT;
            end
            S_SORT: begin
                cmd.sort_en = 1'b1;
                if (r_n == nj_last) begin
                    n_n     = '0;
                    n_m     = '0;
                    n_s     = '0;
                    n_k     = '0;
                    n_state = S_TRY;
                end else begin
                    n_n = r_n + JW'(1);
                end
            end
            S_TRY: begin
                cmd.op       = OP_SPAN;
                cmd.first_m  = (r_m == '0);
                cmd.last_m   = m_last;
                cmd.first_n  = (r_n == '0);
                cmd.eval_end = m_last && (r_n == r_k);
                if (m_last) begin
                    n_m = '0;
                    if (r_n == r_k) begin
                        n_n = '0;
                        if (r_s == r_k) begin
                            n_s     = '0;
                            n_state = S_IDRAIN;
                        end else begin
                            n_s = r_s + JW'(1);
                        end
                    end else begin
                        n_n = r_n + JW'(1);
                    end
                end else begin
                    n_m = r_m + MW'(1);
                end
            end
            S_IDRAIN: begin
                n_state = S_INSERT;
            end
            S_INSERT: begin
                cmd.insert = 1'b1;
                n_n = '0;
                n_m = '0;
                n_s = '0;
                if (r_k == nj_last) begin
                    n_state = S_FINAL;
                end else begin
                    n_k     = r_k + JW'(1);
                    n_state = S_TRY;
                end
            end
            S_FINAL: begin
                cmd.op       = OP_SPAN;
                cmd.plain    = 1'b1;
                cmd.first_m  = (r_m == '0);
                cmd.last_m   = m_last;
                cmd.first_n  = (r_n == '0);
                cmd.eval_end = m_last && (r_n == nj_last);
                if (m_last) begin
                    n_m = '0;
                    if (r_n == nj_last) begin
                        n_n     = '0;
                        n_state = S_FDRAIN;
                    end else begin
                        n_n = r_n + JW'(1);
                    end
                end else begin
                    n_m = r_m + MW'(1);
                end
            end
            S_FDRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                cmd.emit      = 1'b1;
                cmd.emit_last = (r_n == nj_last);
                if (r_n == nj_last) begin
                    n_n     = '0;
                    n_state = S_IDLE;
                end else begin
                    n_n = r_n + JW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_cmd  = cmd;
    assign o_n    = r_n;
    assign o_m    = r_m;
    assign o_s    = r_s;
    assign o_k    = r_k;

`ifndef SYNTHESIS
    a_last_beat_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_last_time) |=> o_busy)
        else $error("final beat did not start the search");
    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRY) |-> (r_s <= r_k && r_n <= r_k))
        else $error("trial slot or position beyond partial sequence");
    a_no_work_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |-> (cmd.op == OP_NONE && !cmd.emit && !cmd.insert))
        else $error("datapath command issued while idle");
`endif

endmodule

`default_nettype wire

@@ design/fsneh_dp.sv @@
// Datapath of the NEH scheduler: time store, weights, sort lanes, span recurrence, output.
`default_nettype none

module fsneh_dp #(
    parameter int MAX_JOBS     = fsneh_pkg::DEF_MAX_JOBS,
    parameter int MAX_MACHINES = fsneh_pkg::DEF_MAX_MACHINES,
    parameter int TIME_BITS    = fsneh_pkg::DEF_TIME_BITS,
    localparam int JW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1,
    localparam int MW  = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1,
    localparam int NCW = $clog2(MAX_JOBS + 1),
    localparam int MCW = $clog2(MAX_MACHINES + 1)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire fsneh_pkg::t_dp_cmd                i_cmd,
    input  wire logic [JW-1:0]                     i_n,
    input  wire logic [MW-1:0]                     i_m,
    input  wire logic [JW-1:0]                     i_s,
    input  wire logic [JW-1:0]                     i_k,
    input  wire logic [NCW-1:0]                    i_nj,
    input  wire logic [MCW-1:0]                    i_nm,
    input  wire logic [TIME_BITS-1:0]              i_proc_time,
    output logic                                   o_result_valid,
    output logic [fsneh_pkg::JOB_INDEX_W-1:0]      o_job_index,
    output logic [fsneh_pkg::SPAN_OUT_W-1:0]       o_makespan,
    output logic                                   o_last_job
);
    import fsneh_pkg::*;

    localparam int DEPTH = MAX_JOBS * MAX_MACHINES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = JW + MCW + 1;
    localparam int WW    = TIME_BITS + $clog2(MAX_MACHINES + 1);
    localparam int SW    = TIME_BITS + $clog2(MAX_JOBS + MAX_MACHINES);
    localparam int CW    = (SW > SPAN_OUT_W) ? SW : SPAN_OUT_W;

    logic [TIME_BITS-1:0] r_mem [DEPTH];
    logic [TIME_BITS-1:0] r_rdata;
    logic [AW-1:0]        r_load_cnt;
    t_dp_cmd              r_tag;
    logic [JW-1:0]        r_t_n, r_t_s;
    logic [MW-1:0]        r_t_m;
    logic [WW-1:0]        r_wacc;
    logic [WW-1:0]        r_weight [MAX_JOBS];
    logic [JW-1:0]        r_order  [MAX_JOBS];
    logic [JW-1:0]        r_seq    [MAX_JOBS];
    logic [SW-1:0]        r_crow   [MAX_MACHINES];
    logic [SW-1:0]        r_left, r_best_span, r_final;
    logic [JW-1:0]        r_best_slot;

    logic [JW-1:0]        seq_idx, seq_val, ord_val, job;
    logic                 use_new;
    logic [PW-1:0]        addr_full;
    logic [AW-1:0]        rd_addr;
    logic [SW-1:0]        cm, lf, mx, v;
    logic [WW-1:0]        wsum;
    logic [WW-1:0]        srt_w [MAX_JOBS];
    logic [JW-1:0]        srt_o [MAX_JOBS];
    logic [CW-1:0]        span_ext;
    logic [SPAN_OUT_W-1:0] span_sat;

    // pick the job of this trial position: old sequence shifted around the slot
    always_comb begin
        use_new = 1'b0;
        if (i_cmd.plain || i_cmd.emit || i_n < i_s) begin
            seq_idx = i_n;
        end else if (i_n == i_s) begin
            seq_idx = i_n;
            use_new = 1'b1;
        end else begin
            seq_idx = i_n - JW'(1);
        end
        seq_val = r_seq[seq_idx];
        ord_val = r_order[i_k];
        if (i_cmd.op == OP_WSUM) begin
            job = i_n;
        end else if (use_new) begin
            job = ord_val;
        end else begin
            job = seq_val;
        end
        addr_full = PW'(job) * PW'(i_nm) + PW'(i_m);
        rd_addr   = addr_full[AW-1:0];
    end

    // max-plus step and weight accumulation on the returned beat
    always_comb begin
        cm   = r_tag.first_n ? '0 : r_crow[r_t_m];
        lf   = r_tag.first_m ? '0 : r_left;
        mx   = (cm > lf) ? cm : lf;
        v    = mx + SW'(r_rdata);
        wsum = (r_tag.first_m ? '0 : r_wacc) + WW'(r_rdata);
    end

    // one odd-even transposition pass; only strictly smaller weights move down
    always_comb begin
        for (int p = 0; p < MAX_JOBS; p++) begin
            srt_w[p] = r_weight[p];
            srt_o[p] = r_order[p];
        end
        for (int p = 0; p + 1 < MAX_JOBS; p++) begin
            if ((p % 2) == int'(i_n[0]) && (p + 1) < int'(i_nj)
                    && r_weight[p] < r_weight[p + 1]) begin
                srt_w[p]     = r_weight[p + 1];
                srt_w[p + 1] = r_weight[p];
                srt_o[p]     = r_order[p + 1];
                srt_o[p + 1] = r_order[p];
            end
        end
    end

    always_comb begin
        span_ext = CW'(r_final);
        span_sat = (span_ext > CW'(SPAN_MAX)) ? SPAN_MAX : SPAN_OUT_W'(span_ext);
    end

    // time store: one write port for loading, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[r_load_cnt] <= i_proc_time;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt     <= '0;
            r_tag          <= '0;
            o_result_valid <= 1'b0;
        end else begin
            r_tag          <= i_cmd;
            o_result_valid <= i_cmd.emit;
            if (i_cmd.init) begin
                r_load_cnt <= '0;
            end else if (i_cmd.load && r_load_cnt != AW'(DEPTH - 1)) begin
                r_load_cnt <= r_load_cnt + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t_n <= i_n;
        r_t_m <= i_m;
        r_t_s <= i_s;
        if (r_tag.op == OP_WSUM) begin
            r_wacc <= wsum;
            if (r_tag.last_m) begin
                r_weight[r_t_n] <= wsum;
            end
        end
        if (r_tag.op == OP_SPAN) begin
            r_crow[r_t_m] <= v;
            r_left        <= v;
            if (r_tag.eval_end) begin
                if (r_tag.plain) begin
                    r_final <= v;
                end else if (r_t_s == '0 || v < r_best_span) begin
                    r_best_span <= v;
                    r_best_slot <= r_t_s;
                end
            end
        end
        if (i_cmd.init) begin
            for (int p = 0; p < MAX_JOBS; p++) begin
                r_order[p] <= JW'(p);
            end
        end else if (i_cmd.sort_en) begin
            for (int p = 0; p < MAX_JOBS; p++) begin
                r_weight[p] <= srt_w[p];
                r_order[p]  <= srt_o[p];
            end
        end
        if (i_cmd.insert) begin
            for (int p = 1; p < MAX_JOBS; p++) begin
                if (p > int'(r_best_slot) && p <= int'(i_k)) begin
                    r_seq[p] <= r_seq[p - 1];
                end
            end
            r_seq[r_best_slot] <= ord_val;
        end
        if (i_cmd.emit) begin
            o_job_index <= JOB_INDEX_W'(seq_val);
            o_makespan  <= span_sat;
            o_last_job  <= i_cmd.emit_last;
        end
    end

endmodule

`default_nettype wire

@@ design/flow_shop_neh_scheduler.sv @@
// Top level of the NEH permutation flow-shop scheduler.
`default_nettype none

// Load processing times job-major, one beat per cycle while busy is low; the
// beat with i_last_time set starts the search and raises busy. With J jobs the
// search computes the job weights, sorts the jobs, runs the insertions and the
// final span, then gives J result beats on consecutive cycles; each makespan
// step reads one time from the single read port of the time store, so that
// port sets the pace of the search. Result beats are strobed by o_result_valid
// for one cycle and cannot be held off.
module flow_shop_neh_scheduler #(
    parameter int MAX_JOBS     = fsneh_pkg::DEF_MAX_JOBS,
    parameter int MAX_MACHINES = fsneh_pkg::DEF_MAX_MACHINES,
    parameter int TIME_BITS    = fsneh_pkg::DEF_TIME_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [TIME_BITS-1:0]              i_proc_time,
    input  wire logic                              i_last_time,
    input  wire logic                              i_cfg_we,
    input  wire logic [fsneh_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [fsneh_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                                   o_result_valid,
    output logic [fsneh_pkg::JOB_INDEX_W-1:0]      o_job_index,
    output logic [fsneh_pkg::SPAN_OUT_W-1:0]       o_makespan,
    output logic                                   o_last_job
);
    import fsneh_pkg::*;

    localparam int JW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int MW  = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int NCW = $clog2(MAX_JOBS + 1);
    localparam int MCW = $clog2(MAX_MACHINES + 1);

    t_dp_cmd        cmd;
    logic [JW-1:0]  n, s, k;
    logic [MW-1:0]  m;
    logic [NCW-1:0] nj;
    logic [MCW-1:0] nm;

    fsneh_ctrl #(
        .MAX_JOBS     (MAX_JOBS),
        .MAX_MACHINES (MAX_MACHINES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_last_time (i_last_time),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (busy),
        .o_cmd       (cmd),
        .o_n         (n),
        .o_m         (m),
        .o_s         (s),
        .o_k         (k),
        .o_nj        (nj),
        .o_nm        (nm)
    );

    fsneh_dp #(
        .MAX_JOBS     (MAX_JOBS),
        .MAX_MACHINES (MAX_MACHINES),
        .TIME_BITS    (TIME_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_n            (n),
        .i_m            (m),
        .i_s            (s),
        .i_k            (k),
        .i_nj           (nj),
        .i_nm           (nm),
        .i_proc_time    (i_proc_time),
        .o_result_valid (o_result_valid),
        .o_job_index    (o_job_index),
        .o_makespan     (o_makespan),
        .o_last_job     (o_last_job)
    );

endmodule

`default_nettype wire
